FILE: hw/rtl/lse_pkg.sv
`timescale 1ns / 1ps

package lse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_W      = 32;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_DUMP = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_wr;   // write the pushed word on top and echo it
      logic pop_dec;   // remove the top entry
      logic rd_start;  // read the top entry and load the walk pointer
      logic rd_next;   // read the entry below the walk pointer
      logic ld_full;   // load a full error result
      logic ld_empty;  // load an empty error result
      logic ld_rd;     // load the word read from the store
      logic rd_last;   // last flag for a loaded read word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic ptr_zero;
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/lse_ctrl.sv
`timescale 1ns / 1ps

module lse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,
   input  lse_pkg::stat_type  stat,
   output lse_pkg::cmd_type   cmd
);

   typedef enum logic {
      S_IDLE,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      dump_ff, dump_in;

   lse_pkg::opcode_type opcode;
   logic                accept;

   assign opcode     = lse_pkg::opcode_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE) && stat.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      dump_in  = dump_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (opcode) inside
                  lse_pkg::OP_PUSH: begin
                     if (stat.full) begin
                        cmd.ld_full = 1'b1;
                     end else begin
                        cmd.push_wr = 1'b1;
                     end
                  end
                  lse_pkg::OP_POP, lse_pkg::OP_PEEK, lse_pkg::OP_DUMP: begin
                     if (stat.empty) begin
                        cmd.ld_empty = 1'b1;
                     end else begin
                        cmd.rd_start = 1'b1;
                        cmd.pop_dec  = (opcode == lse_pkg::OP_POP);
                        dump_in      = (opcode == lse_pkg::OP_DUMP);
                        state_in     = S_LOAD;
                     end
                  end
               endcase
            end
         end
         S_LOAD: begin
            // The read word sits in the store's output register until taken.
            if (stat.out_free) begin
               cmd.ld_rd   = 1'b1;
               cmd.rd_last = !dump_ff || stat.ptr_zero;
               if (dump_ff && !stat.ptr_zero) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dump_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         dump_ff  <= dump_in;
      end
   end

endmodule

FILE: hw/rtl/lse_datapath.sv
`timescale 1ns / 1ps

module lse_datapath #(
   parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lse_pkg::cmd_type           cmd,
   input  logic [lse_pkg::WORD_W-1:0] push_value,
   output lse_pkg::stat_type          stat,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [lse_pkg::WORD_W-1:0] rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [lse_pkg::WORD_W-1:0] mem [STACK_DEPTH];
   logic [lse_pkg::WORD_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  count_m1;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   logic                       out_valid_ff, out_valid_in;
   logic [lse_pkg::WORD_W-1:0] out_word_ff, out_word_in;
   lse_pkg::status_type        out_status_ff, out_status_in;
   logic                       out_last_ff, out_last_in;
   logic                       ld_any;

   assign count_m1 = count_ff - 1'b1;
   assign rd_en    = cmd.rd_start || cmd.rd_next;
   assign rd_addr  = cmd.rd_start ? count_m1[ADDR_W-1:0] : ADDR_W'(ptr_ff - 1'b1);
   assign ld_any   = cmd.push_wr || cmd.ld_full || cmd.ld_empty || cmd.ld_rd;

   assign stat.full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[count_ff[ADDR_W-1:0]] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.push_wr) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (cmd.pop_dec) begin
         count_in = count_m1;
      end
      if (cmd.rd_start || cmd.rd_next) begin
         ptr_in = rd_addr;
      end
   end

   always_comb begin
      out_word_in   = out_word_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (ld_any) begin
         out_valid_in = 1'b1;
      end
      if (cmd.push_wr) begin
         out_word_in   = push_value;
         out_status_in = lse_pkg::ST_OK;
         out_last_in   = 1'b1;
      end else if (cmd.ld_full) begin
         out_word_in   = '0;
         out_status_in = lse_pkg::ST_FULL;
         out_last_in   = 1'b1;
      end else if (cmd.ld_empty) begin
         out_word_in   = '0;
         out_status_in = lse_pkg::ST_EMPTY;
         out_last_in   = 1'b1;
      end else if (cmd.ld_rd) begin
         out_word_in   = rd_data_ff;
         out_status_in = lse_pkg::ST_OK;
         out_last_in   = cmd.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         out_valid_ff <= out_valid_in;
      end
      out_word_ff   <= out_word_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("fill count exceeds the stack depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ld_any |-> stat.out_free)
      else $error("result loaded over an untaken result");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> !stat.full)
      else $error("push written into a full stack");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_next |-> !stat.ptr_zero)
      else $error("dump walked below the bottom entry");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_dec |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("pop did not remove exactly one entry");

endmodule

FILE: hw/rtl/lifo_stack_engine_top.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words.
// Input channel (req_): tuser carries the opcode (push, pop, peek, dump),
// tdata the word to push. Response channel (rsp_): tdata is the word,
// tuser the status (ok, full, empty), tlast marks the final item caused by
// one input item.
// Push, and any input item that fails on a full or empty stack, gives one
// item, loaded into the output register at acceptance; the next input item
// can be taken once that register is free. Pop and peek give one item, read
// into the store's output register and then into the output register; no
// input item is taken in between. A dump of N entries gives N items, top
// first, one per cycle after the first unless the receiver stalls, and the
// next input item is taken once the bottom word is loaded.
// Input items are taken one at a time; a result held in the output register
// does not block acceptance as long as the receiver takes it in that cycle.
// When the receiver stalls, the output register holds its item and the
// input channel stays not ready until the item is taken.
// Reset empties the stack at once; the store contents are not cleared.

module lifo_stack_engine_top #(
   parameter int STACK_DEPTH = lse_pkg::STACK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lse_pkg::WORD_W-1:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]                 req_tuser,   // [1:0] opcode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lse_pkg::WORD_W-1:0] rsp_tdata,   // [31:0] word_out
   output logic [1:0]                 rsp_tuser,   // [1:0] status
   output logic                       rsp_tlast
);

   lse_pkg::cmd_type  cmd;
   lse_pkg::stat_type stat;

   lse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   lse_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_tdata),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: dv/tb_lifo_stack_engine_top.sv
`timescale 1ns / 1ps

module tb_lifo_stack_engine_top;

   localparam int QUIET_LIMIT = 1000;
   localparam int ERR_SHOWN   = 10;
   localparam int MIX_ITEMS   = 15;
   localparam int TAIL_ITEMS  = 10;
   localparam int PLAN_ROWS   = 22;

   typedef struct packed {
      logic [lse_pkg::WORD_W-1:0] word;
      lse_pkg::status_type        status;
      logic                       last;
   } stack_rsp_type;

   // A row either types in its single expected item or leaves it to the predictor.
   typedef struct packed {
      lse_pkg::opcode_type        op;
      logic [lse_pkg::WORD_W-1:0] value;
      logic                       typed;
      logic [lse_pkg::WORD_W-1:0] word;
      lse_pkg::status_type        status;
   } plan_row_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [lse_pkg::WORD_W-1:0] req_tdata  = '0;
   logic [1:0]                 req_tuser  = lse_pkg::OP_PUSH;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [lse_pkg::WORD_W-1:0] rsp_tdata;
   logic [1:0]                 rsp_tuser;
   logic                       rsp_tlast;

   // Shadow copy of the stack.
   logic [lse_pkg::WORD_W-1:0] shadow_store [lse_pkg::STACK_DEPTH];
   int                         shadow_fill = 0;
   stack_rsp_type              predicted_rsp [$];
   stack_rsp_type              pending_rsp [$];

   bit quiet_tail   = 1'b0;
   int error_count  = 0;
   int sent_count   = 0;
   int rsp_count    = 0;
   int full_hits    = 0;
   int empty_hits   = 0;
   int longest_dump = 0;
   int quiet_cycles = 0;
   int stall_left   = 0;

   plan_row_type plan [0:PLAN_ROWS-1] = '{
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, lse_pkg::ST_EMPTY},
      '{lse_pkg::OP_PEEK, 32'h1234_5678, 1'b1, 32'h0000_0000, lse_pkg::ST_EMPTY},
      '{lse_pkg::OP_DUMP, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, lse_pkg::ST_EMPTY},
      '{lse_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, lse_pkg::ST_OK},
      '{lse_pkg::OP_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, lse_pkg::ST_OK},
      '{lse_pkg::OP_PUSH, 32'h0000_0000, 1'b1, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_PUSH, 32'h0000_0001, 1'b1, 32'h0000_0001, lse_pkg::ST_OK},
      '{lse_pkg::OP_PEEK, 32'hDEAD_BEEF, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_DUMP, 32'h5555_5555, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_PEEK, 32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_DUMP, 32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, lse_pkg::ST_EMPTY},
      '{lse_pkg::OP_DUMP, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, lse_pkg::ST_EMPTY},
      '{lse_pkg::OP_PUSH, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, lse_pkg::ST_OK},
      '{lse_pkg::OP_DUMP, 32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK},
      '{lse_pkg::OP_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, lse_pkg::ST_OK}
   };

   lifo_stack_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic stack_rsp_type make_rsp(input logic [lse_pkg::WORD_W-1:0] word,
                                              input lse_pkg::status_type status,
                                              input logic last);
      stack_rsp_type r;
      r.word   = word;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // Applies one input item to the shadow stack and leaves its results in predicted_rsp.
   function automatic void stack_predict(input lse_pkg::opcode_type op,
                                         input logic [lse_pkg::WORD_W-1:0] value);
      predicted_rsp = {};
      if (op == lse_pkg::OP_PUSH) begin
         if (shadow_fill >= lse_pkg::STACK_DEPTH) begin
            predicted_rsp.push_back(make_rsp('0, lse_pkg::ST_FULL, 1'b1));
            full_hits++;
         end else begin
            shadow_store[shadow_fill] = value;
            shadow_fill++;
            predicted_rsp.push_back(make_rsp(value, lse_pkg::ST_OK, 1'b1));
         end
      end else if (shadow_fill == 0) begin
         predicted_rsp.push_back(make_rsp('0, lse_pkg::ST_EMPTY, 1'b1));
         empty_hits++;
      end else if (op == lse_pkg::OP_POP) begin
         shadow_fill--;
         predicted_rsp.push_back(make_rsp(shadow_store[shadow_fill], lse_pkg::ST_OK, 1'b1));
      end else if (op == lse_pkg::OP_PEEK) begin
         predicted_rsp.push_back(make_rsp(shadow_store[shadow_fill-1], lse_pkg::ST_OK, 1'b1));
      end else begin
         for (int i = shadow_fill; i > 0; i--)
            predicted_rsp.push_back(make_rsp(shadow_store[i-1], lse_pkg::ST_OK, i == 1));
         if (shadow_fill > longest_dump) longest_dump = shadow_fill;
      end
   endfunction

   function automatic lse_pkg::opcode_type pick_op(input int push_w, input int pop_w,
                                                   input int peek_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_w) return lse_pkg::OP_PUSH;
      if (r < push_w + pop_w) return lse_pkg::OP_POP;
      if (r < push_w + pop_w + peek_w) return lse_pkg::OP_PEEK;
      return lse_pkg::OP_DUMP;
   endfunction

   function automatic void note_failure(input string msg);
      error_count++;
      if (error_count <= ERR_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   task automatic send_req(input lse_pkg::opcode_type op,
                           input logic [lse_pkg::WORD_W-1:0] value,
                           input logic typed, input stack_rsp_type typed_rsp);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      stack_predict(op, value);
      if (typed) pending_rsp.push_back(typed_rsp);
      else foreach (predicted_rsp[i]) pending_rsp.push_back(predicted_rsp[i]);
      sent_count++;
   endtask

   // Receiver stalls come in bursts of random length, and never in the quiet tail.
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      stack_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            note_failure($sformatf("unexpected item word=%h status=%0d last=%b",
                                   rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata !== want.word || rsp_tuser !== want.status
                || rsp_tlast !== want.last)
               note_failure($sformatf(
                  "expected word=%h status=%0d last=%b, got word=%h status=%0d last=%b",
                  want.word, want.status, want.last, rsp_tdata, rsp_tuser, rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d items still expected.",
                  QUIET_LIMIT, pending_rsp.size());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         send_req(plan[i].op, plan[i].value, plan[i].typed,
                  make_rsp(plan[i].word, plan[i].status, 1'b1));

      // Random mix near the bottom of the stack, so empty rejections recur.
      repeat (MIX_ITEMS)
         send_req(pick_op(45, 30, 10), $urandom, 1'b0, '0);

      // Fill to the top, push twice into the full stack, peek, then dump all of it.
      while (shadow_fill < lse_pkg::STACK_DEPTH)
         send_req(lse_pkg::OP_PUSH, $urandom, 1'b0, '0);
      send_req(lse_pkg::OP_PUSH, $urandom, 1'b0, '0);
      send_req(lse_pkg::OP_PUSH, $urandom, 1'b0, '0);
      send_req(lse_pkg::OP_PEEK, $urandom, 1'b0, '0);
      send_req(lse_pkg::OP_DUMP, $urandom, 1'b0, '0);

      quiet_tail = 1'b1;
      repeat (TAIL_ITEMS)
         send_req(pick_op(20, 50, 15), $urandom, 1'b0, '0);

      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d input items, checked %0d response items, %0d mismatches.",
               sent_count, rsp_count, error_count);
      $display("Saw %0d full and %0d empty rejections; longest dump was %0d words.",
               full_hits, empty_hits, longest_dump);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/lse_pkg.sv
hw/rtl/lse_ctrl.sv
hw/rtl/lse_datapath.sv
hw/rtl/lifo_stack_engine_top.sv
dv/tb_lifo_stack_engine_top.sv
